// ===== hw/rtl/marker_length_frame_checker_core_defines.svh =====
// assertion macros used by the result queue of the marker length frame checker rtl
`ifndef MARKER_LENGTH_FRAME_CHECKER_CORE_DEFINES_SVH
`define MARKER_LENGTH_FRAME_CHECKER_CORE_DEFINES_SVH

// condition that holds at every clock edge outside reset
`define MLFC_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define MLFC_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLFC_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mlfc_pkg.sv =====
// types and constants of the marker length frame checker
`default_nettype none

package mlfc_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned RSP_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MARK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_MARK = 1'd1;

  typedef enum logic [1:0] {
    KIND_TYPE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_GOOD    = 2'd2,
    KIND_BAD     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    kind_t       out_kind;
    logic [7:0]  out_byte;
    logic [15:0] payload_length;
    logic        run_last;
  } rsp_t;

  // results produced by one request, first entry goes out first
  typedef struct packed {
    logic [1:0] count;
    rsp_t       first;
    rsp_t       second;
  } push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mlfc_cfg_regs.sv =====
// start and end marker configuration registers
`default_nettype none

module mlfc_cfg_regs
  import mlfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output logic [7:0]                open_mark,
  output logic [7:0]                close_mark
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_mark  <= 8'd0;
      close_mark <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OPEN_MARK:  open_mark  <= cfg_data;
        CFG_CLOSE_MARK: close_mark <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlfc_parser.sv =====
// frame parsing state machine, turns one byte into up to two results
`default_nettype none

module mlfc_parser
  import mlfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire req_t       req,
  input  wire logic [7:0] open_mark,
  input  wire logic [7:0] close_mark,
  output push_t           push
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_GOT_START  = 4'd1,
    PH_GOT_TYPE   = 4'd2,
    PH_GOT_FORMAT = 4'd3,
    PH_LEN_HI     = 4'd4,
    PH_PAYLOAD    = 4'd5,
    PH_EXPECT_END = 4'd6,
    PH_TRAILING   = 4'd7,
    PH_SKIP       = 4'd8
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  frame_type, frame_type_next;
  logic        long_length_mode, long_length_mode_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] payload_seen, payload_seen_next;
  logic        frame_broken, frame_broken_next;

  logic [15:0] seen_inc;
  logic        have_data;
  logic        framed;
  logic        good;
  rsp_t        data_rsp;
  rsp_t        verdict_rsp;

  assign seen_inc = payload_seen + 16'd1;

  always_comb begin
    phase_next            = phase;
    frame_type_next       = frame_type;
    long_length_mode_next = long_length_mode;
    declared_length_next  = declared_length;
    payload_seen_next     = payload_seen;
    frame_broken_next     = frame_broken;
    have_data             = 1'b0;
    data_rsp              = '0;

    unique case (phase)
      PH_IDLE: begin
        phase_next = (req.data_byte == open_mark) ? PH_GOT_START : PH_SKIP;
      end
      PH_GOT_START: begin
        frame_type_next = req.data_byte;
        phase_next      = PH_GOT_TYPE;
      end
      PH_GOT_TYPE: begin
        long_length_mode_next = (req.data_byte != 8'd0);
        phase_next            = PH_GOT_FORMAT;
      end
      PH_GOT_FORMAT: begin
        have_data             = 1'b1;
        data_rsp.out_kind     = KIND_TYPE;
        data_rsp.out_byte     = frame_type;
        declared_length_next  = {8'd0, req.data_byte};
        if (long_length_mode) begin
          phase_next = PH_LEN_HI;
        end else begin
          phase_next = (req.data_byte == 8'd0) ? PH_EXPECT_END : PH_PAYLOAD;
        end
      end
      PH_LEN_HI: begin
        declared_length_next = {req.data_byte, declared_length[7:0]};
        phase_next = ({req.data_byte, declared_length[7:0]} == 16'd0) ?
                     PH_EXPECT_END : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        have_data         = 1'b1;
        data_rsp.out_kind = KIND_PAYLOAD;
        data_rsp.out_byte = req.data_byte;
        payload_seen_next = seen_inc;
        if (seen_inc >= declared_length) begin
          phase_next = PH_EXPECT_END;
        end
      end
      PH_EXPECT_END: begin
        if (req.data_byte != close_mark) begin
          frame_broken_next = 1'b1;
        end
        phase_next = PH_TRAILING;
      end
      PH_TRAILING: begin
        frame_broken_next = 1'b1;
      end
      default: begin
        phase_next = PH_SKIP;
      end
    endcase

    framed = req.last_byte &&
             ((phase == PH_GOT_FORMAT) || (phase == PH_LEN_HI) ||
              (phase == PH_PAYLOAD) || (phase == PH_EXPECT_END) ||
              (phase == PH_TRAILING));
    good   = (phase == PH_EXPECT_END) && !frame_broken_next;

    verdict_rsp                = '0;
    verdict_rsp.out_kind       = good ? KIND_GOOD : KIND_BAD;
    verdict_rsp.payload_length = declared_length_next;
    verdict_rsp.run_last       = 1'b1;
    data_rsp.run_last          = !framed;

    push.count  = {1'b0, have_data} + {1'b0, framed};
    push.first  = have_data ? data_rsp : verdict_rsp;
    push.second = verdict_rsp;
    if (!fire) begin
      push.count = 2'd0;
    end

    // end of message returns to reset state
    if (req.last_byte) begin
      phase_next            = PH_IDLE;
      frame_type_next       = 8'd0;
      long_length_mode_next = 1'b0;
      declared_length_next  = 16'd0;
      payload_seen_next     = 16'd0;
      frame_broken_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      frame_type       <= 8'd0;
      long_length_mode <= 1'b0;
      declared_length  <= 16'd0;
      payload_seen     <= 16'd0;
      frame_broken     <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      frame_type       <= frame_type_next;
      long_length_mode <= long_length_mode_next;
      declared_length  <= declared_length_next;
      payload_seen     <= payload_seen_next;
      frame_broken     <= frame_broken_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlfc_rsp_fifo.sv =====
// small result queue, takes up to two results a cycle and gives one while the receiver does not stall
`default_nettype none

`include "marker_length_frame_checker_core_defines.svh"

module mlfc_rsp_fifo
  import mlfc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room2,
  output logic       rsp_valid,
  input  wire logic  rsp_stall,
  output rsp_t       rsp
);

  localparam int unsigned PTR_W = $clog2(RSP_DEPTH);
  localparam int unsigned CNT_W = $clog2(RSP_DEPTH + 1);

  rsp_t             mem [RSP_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign rsp_valid = (count != '0);
  assign rsp       = mem[rd_ptr];
  assign pop       = rsp_valid && !rsp_stall;
  assign room2     = (count <= CNT_W'(RSP_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[PTR_W'(wr_ptr + 1'b1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + push.count);
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      count <= CNT_W'(count + CNT_W'(push.count) - CNT_W'(pop));
    end
  end

  `MLFC_CHECK(a_count_max, count <= CNT_W'(RSP_DEPTH), "result queue over depth")
  `MLFC_IMPLY(a_push_room, push.count != 2'd0, room2, "result pushed without room")
  `MLFC_NEXT(a_pop_drains, pop && (push.count == 2'd0),
             count == CNT_W'($past(count) - 1'b1), "pop did not drain queue")

endmodule

`default_nettype wire

// ===== hw/rtl/marker_length_frame_checker_core.sv =====
// Marker and length frame checker. Takes one message byte per cycle on the
// request channel (last_byte flags the end of a message) and streams the
// frame type, the declared payload bytes and a good or bad verdict on the
// result channel. A byte is registered on entry, parsed from the input
// register once the queue has room for two results, and its results land
// in a four entry result queue. Sustained rate is one byte per cycle;
// the last byte of a framed message can give two results, which leave the
// queue one per cycle while the result side does not stall, and the request
// side stalls only while the queue lacks room for two results. Marker
// registers are written on the config channel, which is always ready.
`default_nettype none

module marker_length_frame_checker_core
  import mlfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire req_t                 req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output rsp_t                      rsp,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  logic       in_valid;
  req_t       in_req;
  logic       room2;
  logic       fire;
  logic [7:0] open_mark;
  logic [7:0] close_mark;
  push_t      push;

  assign fire      = in_valid && room2;
  assign req_stall = in_valid && !room2;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!req_stall) begin
      in_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      in_req <= req;
    end
  end

  mlfc_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .open_mark  (open_mark),
    .close_mark (close_mark)
  );

  mlfc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req        (in_req),
    .open_mark  (open_mark),
    .close_mark (close_mark),
    .push       (push)
  );

  mlfc_rsp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the marker length frame checker: directed and random messages checked against a predictor
`default_nettype none

module tb;
  import mlfc_pkg::*;

  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASE_BYTES     = 130;
  localparam int NUM_SETTINGS    = 5;

  typedef enum logic [3:0] {
    WAIT_START, GOT_START, GOT_TYPE, GOT_FORMAT, GOT_LEN_LO,
    IN_PAYLOAD, AT_END, PAST_END, DISCARD
  } parse_state_t;

  class frame_tracker;
    rsp_t         results_due[$];
    int unsigned  errors;
    int unsigned  results_checked;
    int unsigned  good_frames;
    int unsigned  bad_frames;
    logic [7:0]   start_mk;
    logic [7:0]   end_mk;
    parse_state_t state;
    logic [7:0]   type_byte;
    logic         long_len;
    logic [15:0]  decl_len;
    logic [15:0]  seen_cnt;
    logic         broken;

    function new();
      start_mk = 8'h00;
      end_mk   = 8'h00;
      clear_frame();
    endfunction

    function void clear_frame();
      state     = WAIT_START;
      type_byte = 8'h00;
      long_len  = 1'b0;
      decl_len  = 16'h0000;
      seen_cnt  = 16'h0000;
      broken    = 1'b0;
    endfunction

    function void set_marker(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
      if (idx == CFG_OPEN_MARK) begin
        start_mk = v;
      end else begin
        end_mk = v;
      end
    endfunction

    function rsp_t make_result(kind_t k, logic [7:0] b, logic [15:0] len);
      rsp_t r;
      r.out_kind       = k;
      r.out_byte       = b;
      r.payload_length = len;
      r.run_last       = 1'b0;
      return r;
    endfunction

    // advance the parse by one request and queue the results it causes
    function void note_byte(req_t r);
      rsp_t         made[$];
      parse_state_t prev;
      logic [7:0]   b;
      logic         good;
      prev = state;
      b = r.data_byte;
      case (prev)
        WAIT_START: state = (b == start_mk) ? GOT_START : DISCARD;
        GOT_START: begin
          type_byte = b;
          state = GOT_TYPE;
        end
        GOT_TYPE: begin
          long_len = (b != 8'h00);
          state = GOT_FORMAT;
        end
        GOT_FORMAT: begin
          made.push_back(make_result(KIND_TYPE, type_byte, 16'h0000));
          decl_len = {8'h00, b};
          if (long_len) begin
            state = GOT_LEN_LO;
          end else begin
            state = (b == 8'h00) ? AT_END : IN_PAYLOAD;
          end
        end
        GOT_LEN_LO: begin
          decl_len[15:8] = b;
          state = (decl_len == 16'h0000) ? AT_END : IN_PAYLOAD;
        end
        IN_PAYLOAD: begin
          made.push_back(make_result(KIND_PAYLOAD, b, 16'h0000));
          seen_cnt = seen_cnt + 16'd1;
          if (seen_cnt >= decl_len) state = AT_END;
        end
        AT_END: begin
          if (b != end_mk) broken = 1'b1;
          state = PAST_END;
        end
        PAST_END: broken = 1'b1;
        default: state = DISCARD;
      endcase
      if (r.last_byte) begin
        if (prev >= GOT_FORMAT && prev <= PAST_END) begin
          good = (prev == AT_END) && !broken;
          made.push_back(make_result(good ? KIND_GOOD : KIND_BAD, 8'h00, decl_len));
          if (good) good_frames++;
          else bad_frames++;
        end
        clear_frame();
      end
      if (made.size() > 0) made[made.size() - 1].run_last = 1'b1;
      foreach (made[i]) results_due.push_back(made[i]);
    endfunction

    function void report(string field, int unsigned exp_v, int unsigned act_v);
      errors++;
      if (errors <= 20) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      results_checked++;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 20) begin
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0d length %0d",
                   $time, got.out_kind, got.out_byte, got.payload_length);
        end
        return;
      end
      want = results_due.pop_front();
      if (got.out_kind !== want.out_kind) report("out_kind", want.out_kind, got.out_kind);
      if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
      if (got.payload_length !== want.payload_length) begin
        report("payload_length", want.payload_length, got.payload_length);
      end
      if (got.run_last !== want.run_last) report("run_last", want.run_last, got.run_last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OPEN_MARK;
  logic [7:0]           cfg_data = 8'h00;

  frame_tracker sb = new();
  logic [7:0]   msg_bytes[$];
  bit           burst = 1'b0;
  int           hold_off_asks = 0;
  int           bytes_sent = 0;
  int           settings_used = 1;
  int           idle_cycles = 0;

  marker_length_frame_checker_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_byte(req);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // receiver side stall pattern, with an occasional long hold-off
  initial begin
    int pick;
    int holds_done;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if (hold_off_asks != holds_done) begin
        holds_done++;
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          rsp_stall <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else if (pick < 92) begin
          rsp_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          rsp_stall <= 1'b1;
          repeat ($urandom_range(8, 30)) @(posedge clk);
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int pick;
    int gap;
    req_valid <= 1'b1;
    req <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (req_stall);
    bytes_sent++;
    gap = 0;
    if (!burst) begin
      pick = $urandom_range(0, 99);
      if (pick >= 93) gap = $urandom_range(6, 25);
      else if (pick >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_markers(logic [7:0] s, logic [7:0] e);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OPEN_MARK;
    cfg_data  <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_CLOSE_MARK;
    cfg_data  <= e;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_marker(CFG_OPEN_MARK, s);
    sb.set_marker(CFG_CLOSE_MARK, e);
    settings_used++;
  endtask

  task automatic run_directed();
    logic [7:0] s;
    logic [7:0] e;
    s = sb.start_mk;
    e = sb.end_mk;
    msg_bytes = '{~s};
    send_message();
    msg_bytes = '{s, 8'h5A, 8'h00};
    send_message();
    msg_bytes = '{s, 8'hFF, 8'h00, 8'h03};
    send_message();
    // two-byte length cut short at its low byte
    msg_bytes = '{s, 8'h00, 8'h80, 8'h07};
    send_message();
    msg_bytes = '{s, 8'h11, 8'h00, 8'h00, e};
    send_message();
    msg_bytes = '{s, 8'h33, 8'h00, 8'h00, ~e};
    send_message();
    msg_bytes = '{s, 8'h44, 8'hFF, 8'h00, 8'h00, e, 8'h99};
    send_message();
    msg_bytes = '{s, 8'h55, 8'h00, 8'h05, 8'h12};
    send_message();
  endtask

  function automatic void build_random_message();
    int          pick;
    int          n;
    int          cut;
    logic [7:0]  first_b;
    logic [7:0]  fmt;
    logic [15:0] decl;
    msg_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      do first_b = 8'($urandom); while (first_b == sb.start_mk);
      msg_bytes.push_back(first_b);
      repeat ($urandom_range(0, 7)) msg_bytes.push_back(8'($urandom));
    end else if (pick < 27) begin
      msg_bytes.push_back(sb.start_mk);
      repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom));
    end else begin
      fmt = $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'h00;
      pick = $urandom_range(0, 99);
      if (pick < 85) decl = 16'($urandom_range(0, 12));
      else if (pick < 95) decl = 16'($urandom_range(13, 255));
      else decl = 16'($urandom_range(256, 65535));
      if (fmt == 8'h00) decl[15:8] = 8'h00;
      msg_bytes.push_back(sb.start_mk);
      msg_bytes.push_back(8'($urandom));
      msg_bytes.push_back(fmt);
      msg_bytes.push_back(decl[7:0]);
      if (fmt != 8'h00) msg_bytes.push_back(decl[15:8]);
      n = (decl > 16'd255) ? 48 : int'(decl);
      repeat (n) msg_bytes.push_back(8'($urandom));
      cut = 0;
      if (decl > 16'd255) begin
        // long declared payloads are always cut off partway
        cut = $urandom_range(1, msg_bytes.size());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick >= 70 && pick < 80) begin
          msg_bytes.push_back(sb.end_mk ^ 8'($urandom_range(1, 255)));
        end else begin
          msg_bytes.push_back(sb.end_mk);
        end
        if (pick >= 80 && pick < 90) begin
          repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
        end
        cut = (pick >= 90) ? $urandom_range(1, msg_bytes.size() - 1) : msg_bytes.size();
      end
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
  endfunction

  initial begin
    logic [7:0] s_val;
    logic [7:0] e_val;
    int         target;
    bit         pressed;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    drain();
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: begin
          s_val = 8'hFF;
          e_val = 8'hFF;
        end
        1: begin
          s_val = 8'h00;
          e_val = 8'hFF;
        end
        2: begin
          s_val = 8'hFF;
          e_val = 8'h00;
        end
        default: begin
          s_val = 8'($urandom);
          e_val = 8'($urandom);
        end
      endcase
      write_markers(s_val, e_val);
      target = bytes_sent + PHASE_BYTES;
      pressed = 1'b0;
      while (bytes_sent < target) begin
        if (!pressed && bytes_sent >= target - PHASE_BYTES / 2) begin
          // receiver holds off while a long frame streams in back to back
          pressed = 1'b1;
          hold_off_asks++;
          msg_bytes.delete();
          msg_bytes.push_back(sb.start_mk);
          msg_bytes.push_back(8'hC3);
          msg_bytes.push_back(8'h00);
          msg_bytes.push_back(8'd60);
          repeat (60) msg_bytes.push_back(8'($urandom));
          msg_bytes.push_back(sb.end_mk);
          burst = 1'b1;
        end else begin
          build_random_message();
          burst = ($urandom_range(0, 99) < 20);
        end
        send_message();
        burst = 1'b0;
      end
      if (p == NUM_SETTINGS - 1) begin
        // largest declared payload, cut off a few bytes in
        msg_bytes.delete();
        msg_bytes.push_back(sb.start_mk);
        msg_bytes.push_back(8'h7E);
        msg_bytes.push_back(8'h01);
        msg_bytes.push_back(8'hFF);
        msg_bytes.push_back(8'hFF);
        repeat (6) msg_bytes.push_back(8'($urandom));
        burst = 1'b1;
        send_message();
        burst = 1'b0;
      end
      drain();
    end
    $display("sent %0d bytes under %0d marker settings and checked %0d results",
             bytes_sent, settings_used, sb.results_checked);
    $display("frames judged: %0d good, %0d bad", sb.good_frames, sb.bad_frames);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mlfc_pkg.sv
hw/rtl/mlfc_cfg_regs.sv
hw/rtl/mlfc_parser.sv
hw/rtl/mlfc_rsp_fifo.sv
hw/rtl/marker_length_frame_checker_core.sv
dv/tb.sv
